/* src/asgd_pkg.sv */
// Package with the payload types, register indexes and reset values of the Adam/SGD update block.
`default_nettype none
package asgd_pkg;

	localparam int NUM_ELEMENTS_DEF = 1024;
	localparam int INDEX_W = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd4;

	localparam logic MODE_SGD = 1'b0;
	localparam logic MODE_ADAM = 1'b1;

	localparam logic [31:0] LR_RST = 32'd4294967;
	localparam logic [31:0] BETA1_RST = 32'd3865470566;
	localparam logic [31:0] BETA2_RST = 32'd4290672329;
	localparam logic [30:0] EPS_RST = 31'd1;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	typedef struct packed {
		logic [INDEX_W-1:0] element_index;
		logic signed [31:0] param_value;
		logic signed [31:0] gradient;
		logic [15:0] step_count;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_param;
		logic saturated;
	} result_t;

endpackage
`default_nettype wire

/* src/adam_sgd_param_update_top.sv */
// Top level of the Adam/SGD parameter update block with its moment memories and sequencer.
`default_nettype none
// One item is worked on at a time. After reset the block sweeps both moment memories to zero,
// one entry a cycle, and accepts no item until the sweep is done; configuration writes are
// taken at any time. The time of an Adam item is set by the single shared 34x34
// multiplier, which also forms both powers by square-and-multiply, one pass for each bit of
// the step count, and by the radix-2 divider, which runs 64 steps for each of the three
// divisions, together with a 32-step square root. A finished result waits in an output
// register while the next transaction is accepted.
module adam_sgd_param_update_top #(
	parameter int NUM_ELEMENTS = asgd_pkg::NUM_ELEMENTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic item_ready,
	input  wire asgd_pkg::item_t item,
	output logic result_valid,
	input  wire logic result_ready,
	output asgd_pkg::result_t result,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [asgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam int RW = 27;

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_IDX   = 14'b00000000000100,
		S_RD    = 14'b00000000001000,
		S_SGD   = 14'b00000000010000,
		S_MOM   = 14'b00000000100000,
		S_POW   = 14'b00000001000000,
		S_CORR  = 14'b00000010000000,
		S_DIVM  = 14'b00000100000000,
		S_DIVV  = 14'b00001000000000,
		S_SQRT  = 14'b00010000000000,
		S_LRM   = 14'b00100000000000,
		S_DIVS  = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic [AW-1:0] clr_q;
	logic result_valid_q;
	asgd_pkg::result_t result_q;

	logic mode_q;
	logic [31:0] lr_q, b1_q, b2_q;
	logic [30:0] eps_q;

	logic [asgd_pkg::INDEX_W-1:0] red_q;
	logic signed [31:0] p_q, g_q;
	logic [15:0] t_q;
	logic flag_q, neg_q;
	logic signed [31:0] mnew_q;
	logic [63:0] vnew_q, gg_q;
	logic signed [97:0] acc_q;
	logic [32:0] r1_q, r2_q, c2_q, den_q;
	logic [31:0] p1_q, p2_q, mh_q;
	logic [55:0] step_q;

	logic signed [33:0] ma, mb, ma_s1, mb_s1;
	logic signed [67:0] prod_s2;
	logic signed [97:0] prod_x;

	logic [32:0] div_r_q, div_d_q, div_rn;
	logic [63:0] div_l_q, div_q_q, div_qn;
	logic [33:0] div_tmp;
	logic div_ge;

	logic [33:0] sq_rem_q;
	logic [31:0] sq_root_q, sq_rootn;
	logic [63:0] sq_src_q;
	logic [35:0] sq_rem2, sq_trial;
	logic sq_ge;

	logic [31:0] m_mem [NUM_ELEMENTS];
	logic [63:0] v_mem [NUM_ELEMENTS];
	logic [31:0] m_rd_q;
	logic [63:0] v_rd_q;
	logic [AW-1:0] idx, wa;
	logic mem_we;

	logic accept, fin_go, idx_ge, vsat, czero, den_zero;
	logic [RW-1:0] nk;
	logic [31:0] gmag, mmag;
	logic [32:0] c1, c2, den;
	logic [63:0] mh_lim;
	logic signed [57:0] delta, diff;

	localparam logic signed [57:0] MAXV = 58'sd2147483647;
	localparam logic signed [57:0] MINV = -58'sd2147483648;

	assign item_ready = (state_q == S_IDLE);
	assign accept = item_valid && item_ready;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign fin_go = (state_q == S_FIN) && (!result_valid_q || result_ready);

	assign gmag = g_q[31] ? 32'(~g_q + 32'sd1) : 32'(g_q);
	assign mmag = mnew_q[31] ? 32'(~mnew_q + 32'sd1) : 32'(mnew_q);
	assign nk = RW'(NUM_ELEMENTS) << cnt_q[3:0];
	assign idx_ge = {{(RW-asgd_pkg::INDEX_W){1'b0}}, red_q} >= nk;
	assign c1 = asgd_pkg::ONE_Q32 - r1_q;
	assign c2 = asgd_pkg::ONE_Q32 - r2_q;
	assign czero = (c1 == 33'd0) || (c2 == 33'd0);
	assign vsat = {1'b0, vnew_q[63:32]} >= c2_q;
	assign mh_lim = neg_q ? 64'h8000_0000 : 64'h7FFF_FFFF;
	assign den = {1'b0, sq_rootn} + {2'b0, eps_q};
	assign den_zero = (den == 33'd0);
	assign prod_x = {{30{prod_s2[67]}}, prod_s2};

	assign div_tmp = {div_r_q, div_l_q[63]};
	assign div_ge = div_tmp >= {1'b0, div_d_q};
	assign div_rn = div_ge ? 33'(div_tmp - {1'b0, div_d_q}) : div_tmp[32:0];
	assign div_qn = {div_q_q[62:0], div_ge};

	assign sq_rem2 = {sq_rem_q, sq_src_q[63:62]};
	assign sq_trial = {2'b0, sq_root_q, 2'b01};
	assign sq_ge = sq_rem2 >= sq_trial;
	assign sq_rootn = {sq_root_q[30:0], sq_ge};

	assign delta = neg_q ? -$signed({2'b0, step_q}) : $signed({2'b0, step_q});
	assign diff = {{26{p_q[31]}}, p_q} - delta;

	assign idx = AW'(red_q);
	assign mem_we = (state_q == S_CLEAR) || ((state_q == S_MOM) && (cnt_q == 7'd11));
	assign wa = (state_q == S_CLEAR) ? clr_q : idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			m_mem[wa] <= (state_q == S_CLEAR) ? 32'd0 : 32'(mnew_q);
			v_mem[wa] <= (state_q == S_CLEAR) ? 64'd0 : acc_q[95:32];
		end
		m_rd_q <= m_mem[idx];
		v_rd_q <= v_mem[idx];
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SGD: begin
				ma = {2'b0, lr_q};
				mb = {2'b0, gmag};
			end
			S_MOM: begin
				case (cnt_q)
					7'd0: begin
						ma = {2'b0, b1_q};
						mb = {{2{m_rd_q[31]}}, m_rd_q};
					end
					7'd1: begin
						ma = {1'b0, asgd_pkg::ONE_Q32 - {1'b0, b1_q}};
						mb = {{2{g_q[31]}}, g_q};
					end
					7'd2: begin
						ma = {2'b0, gmag};
						mb = {2'b0, gmag};
					end
					7'd5: begin
						ma = {2'b0, v_rd_q[31:0]};
						mb = {2'b0, b2_q};
					end
					7'd6: begin
						ma = {2'b0, v_rd_q[63:32]};
						mb = {2'b0, b2_q};
					end
					7'd7: begin
						ma = {2'b0, gg_q[31:0]};
						mb = {1'b0, asgd_pkg::ONE_Q32 - {1'b0, b2_q}};
					end
					7'd8: begin
						ma = {2'b0, gg_q[63:32]};
						mb = {1'b0, asgd_pkg::ONE_Q32 - {1'b0, b2_q}};
					end
					default: ;
				endcase
			end
			S_POW: begin
				case (cnt_q)
					7'd0: begin
						ma = {1'b0, r1_q};
						mb = {2'b0, p1_q};
					end
					7'd1: begin
						ma = {2'b0, p1_q};
						mb = {2'b0, p1_q};
					end
					7'd2: begin
						ma = {1'b0, r2_q};
						mb = {2'b0, p2_q};
					end
					7'd3: begin
						ma = {2'b0, p2_q};
						mb = {2'b0, p2_q};
					end
					default: ;
				endcase
			end
			S_LRM: begin
				ma = {2'b0, lr_q};
				mb = {2'b0, mh_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ma_s1 <= ma;
		mb_s1 <= mb;
		prod_s2 <= ma_s1 * mb_s1;
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(NUM_ELEMENTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_IDX;
					cnt_d = 7'd9;
				end
			end
			S_IDX: begin
				if (cnt_q == 7'd0) state_d = S_RD;
				else cnt_d = cnt_q - 7'd1;
			end
			S_RD: begin
				state_d = (mode_q == asgd_pkg::MODE_ADAM) ? S_MOM : S_SGD;
				cnt_d = 7'd0;
			end
			S_SGD: begin
				if (cnt_q == 7'd2) state_d = S_FIN;
				else cnt_d = cnt_q + 7'd1;
			end
			S_MOM: begin
				if (cnt_q == 7'd11) begin
					state_d = S_POW;
					cnt_d = 7'd0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_POW: begin
				if (cnt_q == 7'd0 && t_q == 16'd0) state_d = S_CORR;
				else if (cnt_q == 7'd5) cnt_d = 7'd0;
				else cnt_d = cnt_q + 7'd1;
			end
			S_CORR: begin
				state_d = czero ? S_FIN : S_DIVM;
				cnt_d = 7'd0;
			end
			S_DIVM: begin
				if (cnt_q == 7'd63) begin
					state_d = vsat ? S_SQRT : S_DIVV;
					cnt_d = 7'd0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_DIVV: begin
				if (cnt_q == 7'd63) begin
					state_d = S_SQRT;
					cnt_d = 7'd0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_SQRT: begin
				if (cnt_q == 7'd31) begin
					state_d = den_zero ? S_FIN : S_LRM;
					cnt_d = 7'd0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_LRM: begin
				if (cnt_q == 7'd2) begin
					state_d = S_DIVS;
					cnt_d = 7'd0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_DIVS: begin
				if (cnt_q == 7'd63) state_d = S_FIN;
				else cnt_d = cnt_q + 7'd1;
			end
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
			result_valid_q <= 1'b0;
			mode_q <= asgd_pkg::MODE_ADAM;
			lr_q <= asgd_pkg::LR_RST;
			b1_q <= asgd_pkg::BETA1_RST;
			b2_q <= asgd_pkg::BETA2_RST;
			eps_q <= asgd_pkg::EPS_RST;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (fin_go) result_valid_q <= 1'b1;
			else if (result_ready) result_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					asgd_pkg::REG_MODE: mode_q <= cfg_data[0];
					asgd_pkg::REG_LEARNING_RATE: lr_q <= cfg_data;
					asgd_pkg::REG_DECAY_FIRST: b1_q <= cfg_data;
					asgd_pkg::REG_DECAY_SECOND: b2_q <= cfg_data;
					asgd_pkg::REG_EPSILON: eps_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					red_q <= item.element_index;
					p_q <= item.param_value;
					g_q <= item.gradient;
					t_q <= item.step_count;
					flag_q <= 1'b0;
				end
			end
			S_IDX: begin
				if (idx_ge) red_q <= asgd_pkg::INDEX_W'({{(RW-asgd_pkg::INDEX_W){1'b0}}, red_q} - nk);
			end
			S_RD: begin
				r1_q <= asgd_pkg::ONE_Q32;
				r2_q <= asgd_pkg::ONE_Q32;
				p1_q <= b1_q;
				p2_q <= b2_q;
			end
			S_SGD: begin
				if (cnt_q == 7'd2) begin
					step_q <= {24'd0, prod_s2[63:32]};
					neg_q <= g_q[31];
				end
			end
			S_MOM: begin
				case (cnt_q)
					7'd2: acc_q <= prod_x;
					7'd3: acc_q <= acc_q + prod_x;
					7'd4: begin
						mnew_q <= acc_q[63:32];
						gg_q <= prod_s2[63:0];
					end
					7'd7: acc_q <= prod_x;
					7'd8: acc_q <= acc_q + {prod_x[65:0], 32'd0};
					7'd9: acc_q <= acc_q + prod_x;
					7'd10: acc_q <= acc_q + {prod_x[65:0], 32'd0};
					7'd11: vnew_q <= acc_q[95:32];
					default: ;
				endcase
			end
			S_POW: begin
				case (cnt_q)
					7'd2: if (t_q[0]) r1_q <= prod_s2[64:32];
					7'd3: p1_q <= prod_s2[63:32];
					7'd4: if (t_q[0]) r2_q <= prod_s2[64:32];
					7'd5: begin
						p2_q <= prod_s2[63:32];
						t_q <= t_q >> 1;
					end
					default: ;
				endcase
			end
			S_CORR: begin
				c2_q <= c2;
				neg_q <= mnew_q[31];
				if (czero) begin
					flag_q <= 1'b1;
					step_q <= '0;
				end else begin
					div_r_q <= '0;
					div_l_q <= {mmag, 32'd0};
					div_q_q <= '0;
					div_d_q <= c1;
				end
			end
			S_DIVM: begin
				if (cnt_q == 7'd63) begin
					if (div_qn > mh_lim) begin
						mh_q <= mh_lim[31:0];
						flag_q <= 1'b1;
					end else begin
						mh_q <= div_qn[31:0];
					end
					sq_rem_q <= '0;
					sq_root_q <= '0;
					if (vsat) begin
						sq_src_q <= '1;
						flag_q <= 1'b1;
					end else begin
						div_r_q <= {1'b0, vnew_q[63:32]};
						div_l_q <= {vnew_q[31:0], 32'd0};
						div_q_q <= '0;
						div_d_q <= c2_q;
					end
				end else begin
					div_r_q <= div_rn;
					div_l_q <= div_l_q << 1;
					div_q_q <= div_qn;
				end
			end
			S_DIVV: begin
				div_r_q <= div_rn;
				div_l_q <= div_l_q << 1;
				div_q_q <= div_qn;
				if (cnt_q == 7'd63) sq_src_q <= div_qn;
			end
			S_SQRT: begin
				sq_rem_q <= sq_ge ? 34'(sq_rem2 - sq_trial) : sq_rem2[33:0];
				sq_root_q <= sq_rootn;
				sq_src_q <= sq_src_q << 2;
				if (cnt_q == 7'd31) begin
					den_q <= den;
					if (den_zero) begin
						flag_q <= 1'b1;
						step_q <= '0;
					end
				end
			end
			S_LRM: begin
				if (cnt_q == 7'd2) begin
					div_r_q <= '0;
					div_l_q <= {8'd0, prod_s2[63:8]};
					div_q_q <= '0;
					div_d_q <= den_q;
				end
			end
			S_DIVS: begin
				div_r_q <= div_rn;
				div_l_q <= div_l_q << 1;
				div_q_q <= div_qn;
				if (cnt_q == 7'd63) step_q <= div_qn[55:0];
			end
			S_FIN: begin
				if (fin_go) begin
					if (diff > MAXV) begin
						result_q.new_param <= 32'sh7FFF_FFFF;
						result_q.saturated <= 1'b1;
					end else if (diff < MINV) begin
						result_q.new_param <= 32'sh8000_0000;
						result_q.saturated <= 1'b1;
					end else begin
						result_q.new_param <= diff[31:0];
						result_q.saturated <= flag_q;
					end
				end
			end
			default: ;
		endcase
	end

	a_mem_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_MOM))
		else $error("Moment memory written outside the clear pass or write-back");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_FIN))
		else $error("Result raised without a finished transaction");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVM || state_q == S_DIVV || state_q == S_DIVS) |-> (div_r_q < div_d_q))
		else $error("Divider remainder not below divisor");

	a_power_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POW) |-> (r1_q <= asgd_pkg::ONE_Q32 && r2_q <= asgd_pkg::ONE_Q32))
		else $error("Power accumulator above one");

endmodule
`default_nettype wire

/* verif/adam_sgd_param_update_top_tb.sv */
// Self-checking testbench for the Adam/SGD parameter update block, with predictor, driver and monitor.
`default_nettype none
module adam_sgd_param_update_top_tb;
	import asgd_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 400;
	localparam int NUM_RANDOM = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	item_t pending_items[$];
	result_t expected_results[$];

	logic opt_mode;
	logic [31:0] step_size;
	logic [31:0] beta1;
	logic [31:0] beta2;
	logic [30:0] eps_q24;
	logic [31:0] first_mom[NUM_ELEMENTS_DEF];
	logic [63:0] second_mom[NUM_ELEMENTS_DEF];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	adam_sgd_param_update_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [32:0] decay_power(logic [31:0] base_q32, logic [15:0] t);
		logic [127:0] acc;
		logic [127:0] sq;
		acc = 128'(ONE_Q32);
		sq = 128'(base_q32);
		for (int k = 0; k < 16; k++) begin
			if (t[k])
				acc = (acc * sq) >> 32;
			sq = (sq * sq) >> 32;
		end
		return acc[32:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic result_t predict_update(item_t it);
		logic [9:0] ix;
		logic signed [63:0] p;
		logic signed [63:0] g;
		logic signed [63:0] m;
		logic signed [63:0] delta;
		logic signed [63:0] res;
		logic signed [95:0] s;
		logic [63:0] gmag;
		logic [63:0] mmag;
		logic [63:0] v;
		logic [63:0] mh;
		logic [63:0] lim;
		logic [63:0] vh;
		logic [63:0] den;
		logic [63:0] stepm;
		logic [127:0] wide;
		logic [32:0] c1;
		logic [32:0] c2;
		logic flag;
		result_t r;
		ix = it.element_index;
		p = it.param_value;
		g = it.gradient;
		gmag = g < 0 ? -g : g;
		flag = 1'b0;
		delta = 0;
		if (opt_mode == MODE_SGD) begin
			stepm = (64'(step_size) * gmag) >> 32;
			delta = $signed(stepm);
			if (g < 0)
				delta = -delta;
		end else begin
			m = $signed(first_mom[ix]);
			s = $signed({32'b0, beta1}) * m + $signed({31'b0, 33'(ONE_Q32 - beta1)}) * g;
			m = 64'(s >>> 32);
			first_mom[ix] = m[31:0];
			wide = 128'(second_mom[ix]) * beta2 + 128'(gmag * gmag) * 128'(ONE_Q32 - beta2);
			v = 64'(wide >> 32);
			second_mom[ix] = v;
			c1 = ONE_Q32 - decay_power(beta1, it.step_count);
			c2 = ONE_Q32 - decay_power(beta2, it.step_count);
			if (c1 == 0 || c2 == 0) begin
				flag = 1'b1;
			end else begin
				mmag = m < 0 ? -m : m;
				mh = 64'((128'(mmag) << 32) / c1);
				lim = m < 0 ? 64'd2147483648 : 64'd2147483647;
				if (mh > lim) begin
					mh = lim;
					flag = 1'b1;
				end
				if ((v >> 32) >= c2) begin
					vh = '1;
					flag = 1'b1;
				end else begin
					vh = 64'((128'(v) << 32) / c2);
				end
				den = int_sqrt(vh) + eps_q24;
				if (den == 0) begin
					flag = 1'b1;
				end else begin
					stepm = 64'((128'(step_size) * mh) / (128'(den) << 8));
					delta = $signed(stepm);
					if (m < 0)
						delta = -delta;
				end
			end
		end
		res = p - delta;
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			flag = 1'b1;
		end else if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			flag = 1'b1;
		end
		r.new_param = res[31:0];
		r.saturated = flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(predict_update(item));
			if (!item_valid || item_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: new_param %0d saturated %0b",
							result.new_param, result.saturated);
				end else begin
					result_t want;
					want = expected_results.pop_front();
					if (result.new_param !== want.new_param || result.saturated !== want.saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: new_param %0d/%0d saturated %0b/%0b (exp/act)",
								want.new_param, result.new_param, want.saturated, result.saturated);
					end
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE: opt_mode = data[0];
			REG_LEARNING_RATE: step_size = data;
			REG_DECAY_FIRST: beta1 = data;
			REG_DECAY_SECOND: beta2 = data;
			REG_EPSILON: eps_q24 = data[30:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	task automatic set_all(logic md, logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
			logic [30:0] ep);
		write_reg(REG_MODE, {31'b0, md});
		write_reg(REG_LEARNING_RATE, lr);
		write_reg(REG_DECAY_FIRST, b1);
		write_reg(REG_DECAY_SECOND, b2);
		write_reg(REG_EPSILON, {1'b0, ep});
	endtask

	function automatic item_t make_item(int ix, logic [31:0] p, logic [31:0] g, int t);
		item_t it;
		it.element_index = ix[9:0];
		it.param_value = p;
		it.gradient = g;
		it.step_count = t[15:0];
		return it;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $signed($urandom_range(1 << 26)) - (1 << 25);
		endcase
	endfunction

	function automatic item_t rand_item();
		int ix;
		int t;
		ix = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(7);
		case ($urandom_range(19))
			0: t = $urandom_range(65535);
			1: t = 0;
			default: t = $urandom_range(1, 60);
		endcase
		return make_item(ix, rand_value(), rand_value(), t);
	endfunction

	initial begin
		opt_mode = MODE_ADAM;
		step_size = LR_RST;
		beta1 = BETA1_RST;
		beta2 = BETA2_RST;
		eps_q24 = EPS_RST;
		for (int k = 0; k < NUM_ELEMENTS_DEF; k++) begin
			first_mom[k] = '0;
			second_mom[k] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		pending_items.push_back(make_item(0, 32'h0100_0000, 32'h0001_0000, 1));
		pending_items.push_back(make_item(0, 32'h0100_0000, 32'h0001_0000, 2));
		pending_items.push_back(make_item(1023, 32'h7fff_ffff, 32'h8000_0000, 1));
		pending_items.push_back(make_item(1023, 32'h8000_0000, 32'h7fff_ffff, 65535));
		pending_items.push_back(make_item(5, 32'h0, 32'h0100_0000, 0));
		pending_items.push_back(make_item(6, 32'hffff_ffff, 32'hffff_ffff, 3));
		wait_drained();

		write_reg(3'd5, 32'hffff_ffff);
		write_reg(3'd7, 32'h0);
		set_all(MODE_SGD, 32'hffff_ffff, 32'h0, 32'h0, 31'h7fff_ffff);
		pending_items.push_back(make_item(2, 32'h8000_0000, 32'h7fff_ffff, 1));
		pending_items.push_back(make_item(2, 32'h7fff_ffff, 32'h8000_0000, 1));
		pending_items.push_back(make_item(3, 32'h0, 32'hffff_ffff, 0));
		pending_items.push_back(make_item(3, 32'h1234_5678, 32'h0, 65535));
		wait_drained();

		set_all(MODE_ADAM, 32'hffff_ffff, 32'h0, 32'h0, 31'h0);
		pending_items.push_back(make_item(9, 32'h0100_0000, 32'h0, 1));
		pending_items.push_back(make_item(9, 32'h0100_0000, 32'h8000_0000, 1));
		pending_items.push_back(make_item(10, 32'h7fff_ffff, 32'h7fff_ffff, 4));
		wait_drained();

		set_all(MODE_ADAM, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
		pending_items.push_back(make_item(11, 32'h0, 32'h8000_0000, 1));
		pending_items.push_back(make_item(11, 32'h0, 32'h7fff_ffff, 65535));
		pending_items.push_back(make_item(12, 32'h8000_0000, 32'h0001_0000, 7));
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 58;
			end else if (ph < 4) begin
				send_idle_pct = 58;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 5)
				set_all(MODE_ADAM, LR_RST, BETA1_RST, BETA2_RST, EPS_RST);
			else
				set_all(ph % 3 == 1 ? MODE_SGD : MODE_ADAM,
					$urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 28),
					$urandom_range(3) == 0 ? $urandom() : 32'hf000_0000 + $urandom_range(1 << 27),
					$urandom_range(3) == 0 ? $urandom() : 32'hff00_0000 + $urandom_range(1 << 23),
					$urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(1 << 12)));
			if (ph == 4)
				hold_request = 1500;
			for (int k = 0; k < NUM_RANDOM / 6; k++)
				pending_items.push_back(rand_item());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
